>>> rtl/deadline_timer_queue_macros.svh
// Assertion helpers for the timer queue checker.
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define DTQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtq assertion failed");
// Next-cycle implication outside reset.
`define DTQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtq assertion failed");
`endif

>>> rtl/dtq_pkg.sv
package dtq_pkg;
  localparam int unsigned TimeW = 48;
  localparam int unsigned IdW = 31;
  localparam logic [IdW-1:0] IdMax = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    REQ_SCHED = 2'd0,
    REQ_CANCEL = 2'd1,
    REQ_ADVANCE = 2'd2,
    REQ_NONE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_SCHEDULED = 3'd0,
    ST_FULL = 3'd1,
    ST_CANCELLED = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FIRED = 3'd4,
    ST_ADV_DONE = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_SCAN_WAIT, S_IDCHK, S_IDCHK_WAIT, S_WRITE,
    S_RESULT, S_FIRE_EMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic signed [31:0] delay_ms;
    logic [30:0] timer_id;
    logic [15:0] elapsed_ms;
  } req_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [30:0] timer_id_res;
    logic signed [31:0] next_timeout;
    logic        last;
  } res_item_t;
endpackage

>>> rtl/deadline_timer_queue.sv
// Channel  | Direction | Handshake            | Payload
// request  | in        | start & !busy        | req (req_item_t)
// result   | out       | res_valid, 1 cycle   | res (res_item_t)
//
// Each walk reads the slot memory one entry per cycle (one read port, registered
// data). Cancel, or an advance that fires nothing: busy through one walk and S_RESULT
// after acceptance; the result shows in the cycle busy drops. Schedule: one id-check
// walk per candidate id, repeated while it is in use; a full table answers next cycle.
// Each fired timer adds a walk, a pick and an emit before the final walk.
// Reset (rst, synchronous) clears valid bits, the id counter and the clock.
// The receiver cannot stall: each result is shown for one cycle only.
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  req_item_t req,
  output logic      busy,
  output logic      res_valid,
  output res_item_t res
);
  localparam int unsigned AW = $clog2(TIMER_SLOTS);

  // slot memory: deadline and id, one write and one read port
  logic [TimeW+IdW-1:0] mem [TIMER_SLOTS];
  logic [TimeW+IdW-1:0] rd_data;
  logic [AW-1:0] rd_addr;
  logic wr_en;
  logic [AW-1:0] wr_addr;
  logic [TimeW+IdW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  logic [TIMER_SLOTS-1:0] valid;
  logic [IdW-1:0] last_id;
  logic [TimeW-1:0] now;
  state_t state;
  req_item_t cur;
  logic [AW-1:0] cnt;       // address being issued
  logic [AW-1:0] rd_idx;    // address of data in rd_data
  logic rd_live;
  logic found;
  logic [AW-1:0] best_idx;
  logic [TimeW-1:0] best_dl;
  logic [IdW-1:0] best_id;
  logic [IdW-1:0] cand_id;
  logic [AW-1:0] free_idx;

  state_t state_next;
  req_item_t cur_next;
  logic [AW-1:0] cnt_next;
  logic rd_live_next;
  logic found_next;
  logic [AW-1:0] best_idx_next;
  logic [TimeW-1:0] best_dl_next;
  logic [IdW-1:0] best_id_next;
  logic [IdW-1:0] cand_id_next;
  logic [AW-1:0] free_idx_next;
  logic [TIMER_SLOTS-1:0] valid_next;
  logic [IdW-1:0] last_id_next;
  logic [TimeW-1:0] now_next;
  res_item_t res_next;
  logic res_valid_next;
  logic wr_en_next;
  logic [AW-1:0] wr_addr_next;
  logic [TimeW+IdW-1:0] wr_data_next;

  assign busy = (state != S_IDLE);
  assign rd_addr = cnt;

  wire [TimeW-1:0] rd_dl = rd_data[TimeW+IdW-1:IdW];
  wire [IdW-1:0] rd_id = rd_data[IdW-1:0];
  wire rd_ok = rd_live && valid[rd_idx];
  wire [IdW-1:0] id_step = (last_id >= IdMax) ? IdW'(1) : last_id + IdW'(1);
  wire [IdW-1:0] cand_step = (cand_id >= IdMax) ? IdW'(1) : cand_id + IdW'(1);
  wire [TimeW-1:0] dly = cur.delay_ms[31] ? '0 : TimeW'(unsigned'(cur.delay_ms));
  wire [TimeW-1:0] left = best_dl - now;

  logic [AW-1:0] first_free;
  logic any_free;
  always_comb begin
    first_free = '0;
    any_free = 1'b0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        first_free = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  // next state and datapath
  always_comb begin
    state_next = state;
    cur_next = cur;
    cnt_next = cnt;
    rd_live_next = 1'b0;
    found_next = found;
    best_idx_next = best_idx;
    best_dl_next = best_dl;
    best_id_next = best_id;
    cand_id_next = cand_id;
    free_idx_next = free_idx;
    valid_next = valid;
    last_id_next = last_id;
    now_next = now;
    res_next = res;
    res_valid_next = 1'b0;
    wr_en_next = 1'b0;
    wr_addr_next = wr_addr;
    wr_data_next = wr_data;
    unique case (state)
      S_IDLE: if (start) begin
        cur_next = req;
        cnt_next = '0;
        found_next = 1'b0;
        free_idx_next = first_free;
        unique case (req.req_type)
          REQ_SCHED: begin
            if (!any_free) begin
              res_next = '{ST_FULL, '0, '0, 1'b1};
              res_valid_next = 1'b1;
            end else begin
              cand_id_next = id_step;
              state_next = S_IDCHK;
            end
          end
          REQ_CANCEL: state_next = S_SCAN;
          REQ_ADVANCE: begin
            now_next = now + TimeW'(req.elapsed_ms);
            state_next = S_SCAN;
          end
          default: ;
        endcase
      end
      // walk for cancel match or earliest entry
      S_SCAN, S_SCAN_WAIT: begin
        if (state == S_SCAN) begin
          rd_live_next = 1'b1;
          if (cnt == AW'(TIMER_SLOTS - 1)) state_next = S_SCAN_WAIT;
          else cnt_next = cnt + AW'(1);
        end else state_next = S_RESULT;
        if (rd_ok) begin
          if (cur.req_type == REQ_CANCEL) begin
            if (cur.timer_id != '0 && rd_id == cur.timer_id && !found) begin
              found_next = 1'b1;
              best_idx_next = rd_idx;
            end
          end else if (!found || rd_dl < best_dl ||
                       (rd_dl == best_dl && rd_id < best_id)) begin
            found_next = 1'b1;
            best_idx_next = rd_idx;
            best_dl_next = rd_dl;
            best_id_next = rd_id;
          end
        end
      end
      // walk checking candidate id against valid entries
      S_IDCHK, S_IDCHK_WAIT: begin
        if (state == S_IDCHK) begin
          rd_live_next = 1'b1;
          if (cnt == AW'(TIMER_SLOTS - 1)) state_next = S_IDCHK_WAIT;
          else cnt_next = cnt + AW'(1);
        end else state_next = S_WRITE;
        if (rd_ok && rd_id == cand_id) found_next = 1'b1;
      end
      S_WRITE: begin
        cnt_next = '0;
        if (found) begin
          found_next = 1'b0;
          cand_id_next = cand_step;
          state_next = S_IDCHK;
        end else begin
          last_id_next = cand_id;
          wr_en_next = 1'b1;
          wr_addr_next = free_idx;
          wr_data_next = {now + dly, cand_id};
          valid_next[free_idx] = 1'b1;
          res_next = '{ST_SCHEDULED, cand_id, '0, 1'b1};
          res_valid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_RESULT: begin
        res_valid_next = 1'b1;
        if (cur.req_type == REQ_CANCEL) begin
          state_next = S_IDLE;
          if (found) begin
            valid_next[best_idx] = 1'b0;
            res_next = '{ST_CANCELLED, cur.timer_id, '0, 1'b1};
          end else res_next = '{ST_NOT_FOUND, '0, '0, 1'b1};
        end else if (found && best_dl <= now) begin
          // due timer: emit it, then walk again for the next one
          valid_next[best_idx] = 1'b0;
          res_next = '{ST_FIRED, best_id, '0, 1'b0};
          state_next = S_FIRE_EMIT;
        end else if (!found) begin
          state_next = S_IDLE;
          res_next = '{ST_ADV_DONE, '0, -32'sd1, 1'b1};
        end else begin
          state_next = S_IDLE;
          res_next = '{ST_ADV_DONE, '0,
                       (left > TimeW'(IdMax)) ? 32'sh7FFF_FFFF : signed'(left[31:0]), 1'b1};
        end
      end
      S_FIRE_EMIT: begin
        cnt_next = '0;
        found_next = 1'b0;
        state_next = S_SCAN;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= '0;
      last_id <= '0;
      now <= '0;
      cnt <= '0;
      rd_live <= 1'b0;
      res_valid <= 1'b0;
      wr_en <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      last_id <= last_id_next;
      now <= now_next;
      cnt <= cnt_next;
      rd_live <= rd_live_next;
      res_valid <= res_valid_next;
      wr_en <= wr_en_next;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= rd_addr;
    cur <= cur_next;
    found <= found_next;
    best_idx <= best_idx_next;
    best_dl <= best_dl_next;
    best_id <= best_id_next;
    cand_id <= cand_id_next;
    free_idx <= free_idx_next;
    res <= res_next;
    wr_addr <= wr_addr_next;
    wr_data <= wr_data_next;
  end
endmodule

>>> rtl/dtq_checker.sv
`include "deadline_timer_queue_macros.svh"
module dtq_checker import dtq_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      start,
  input logic      busy,
  input logic      res_valid,
  input res_item_t res
);
  `DTQ_ASSERT_IMP(a_idle_no_res, !busy && !$past(busy) && !$past(start), !res_valid)
  `DTQ_ASSERT_IMP(a_last_idle, res_valid && res.last, !busy)
  `DTQ_ASSERT_IMP(a_fired_busy, res_valid && !res.last, busy)
  `DTQ_ASSERT_IMP(a_id_nz, res_valid && res.status == ST_SCHEDULED, res.timer_id_res != '0)
endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
